@@ rtl/core/kls_pkg.sv @@
// kls_pkg: shared types and constants of the keyed slot log store
// no dependencies; imported by kls_slot_mem, keyed_slot_log_store and the bench
package kls_pkg;

    localparam int SEQ_W  = 8;
    localparam int ADDR_W = 48;
    localparam int CAL_W  = 64;
    localparam int SLOT_W = 4;
    localparam int CFG_W  = 4;
    localparam int TD_W   = 256;

    localparam logic [1:0] OP_FIND = 2'd0;
    localparam logic [1:0] OP_LOAD = 2'd1;
    localparam logic [1:0] OP_SAVE = 2'd2;

    localparam logic [SLOT_W-1:0] NO_SLOT    = 4'hF;
    localparam logic [CFG_W-1:0]  SLOTS_RST  = 4'd8;
    localparam logic [SEQ_W-1:0]  SEQ_START  = 8'hFF;
    localparam logic              REG_SLOTS  = 1'b0;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [ADDR_W-1:0] addr;
        logic [CAL_W-1:0]  cal_lo;
        logic [CAL_W-1:0]  cal_mid;
        logic [CAL_W-1:0]  cal_hi;
    } t_slot;

endpackage

@@ rtl/core/keyed_slot_log_store.sv @@
// keyed_slot_log_store: slot store with find, load and save, driven by a small sequencer
// depends on kls_pkg and kls_slot_mem
//
//  channel   dir   beat contents
//  s_t*      in    one request: op, slot_sel, dev_addr, seq_given, calibration record
//  m_t*      out   one result: slot_used, entry_valid, seq_out, addr_out, cal_out
//  apb       cfg   register 0 slots_in_use at byte address 0
//
// a find scans the slots in use up to the first match; a load reads one slot; a save reads its chosen slot,
// or scans the slots in use for a gap, then writes; the slot memory is scanned one slot a cycle
// through its single registered read port, with one compare unit checking each slot
// s_tready is low while a request is in work and while its result waits for the output
// register to free up
// reset is synchronous: all slots empty, slots_in_use 8, no result pending
module keyed_slot_log_store #(
    parameter int MAX_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[1:0], slot_sel[5:2], dev_addr[53:6], seq_given[61:54], cal_lo[125:62],
    // cal_mid[189:126], cal_hi[253:190], zero[255:254]
    input  logic [kls_pkg::TD_W-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // slot_used[3:0], entry_valid[4], seq_out[12:5], addr_out[60:13], cal_out_lo[124:61],
    // cal_out_mid[188:125], cal_out_hi[252:189], zero[255:253]
    output logic [kls_pkg::TD_W-1:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kls_pkg::*;

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIND  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_PICK  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_idx, n_idx;
    logic [SEQ_W-1:0]  r_prev, n_prev;
    logic              r_seen, n_seen;
    logic [SEQ_W-1:0]  r_wseq, n_wseq;
    logic [SLOT_W-1:0] r_res_slot, n_res_slot;
    logic              r_res_hit, n_res_hit;
    logic [SEQ_W-1:0]  r_res_seq, n_res_seq;
    logic              r_res_ld, n_res_ld;
    logic [CFG_W-1:0]  r_cfg;
    logic              r_ov;
    logic [TD_W-1:0]   r_otd;

    logic [SEQ_W-1:0]  r_seqg;
    logic [ADDR_W-1:0] r_addr;
    logic [CAL_W-1:0]  r_cal_lo, r_cal_mid, r_cal_hi;

    logic [1:0]        in_op;
    logic [SLOT_W-1:0] in_sel;
    logic [CW-1:0]     act_n;
    logic              accept, load_ok, pick_ok, cur_valid, last, out_load;
    logic [SEQ_W-1:0]  seq_inc;
    t_slot             rd_data, wr_data;
    logic [MAX_SLOTS-1:0] valid_vec;
    logic              wr_en;
    logic [ADDR_W-1:0] o_addr;
    logic [CAL_W-1:0]  o_lo, o_mid, o_hi;

    assign in_op  = s_tdata[1:0];
    assign in_sel = s_tdata[5:2];
    assign accept = s_tvalid && s_tready;
    assign s_tready = (r_state == S_IDLE);

    assign act_n   = (r_cfg > CFG_W'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(r_cfg);
    assign load_ok = !in_sel[3] && ({1'b0, in_sel[2:0]} < SLOT_W'(MAX_SLOTS));
    assign pick_ok = !in_sel[3] && ({1'b0, in_sel[2:0]} < SLOT_W'(act_n));

    assign cur_valid = valid_vec[r_idx[IW-1:0]];
    assign last      = (CW'(r_idx + 1'b1) == act_n);
    assign seq_inc   = r_prev + 1'b1;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_prev     = r_prev;
        n_seen     = r_seen;
        n_wseq     = r_wseq;
        n_res_slot = r_res_slot;
        n_res_hit  = r_res_hit;
        n_res_seq  = r_res_seq;
        n_res_ld   = r_res_ld;
        wr_en      = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_res_slot = NO_SLOT;
                n_res_hit  = 1'b0;
                n_res_seq  = '0;
                n_res_ld   = 1'b0;
                if (accept) begin
                    n_state = S_DONE;
                    case (in_op)
                        OP_FIND: begin
                            if (act_n != '0) begin
                                n_idx   = '0;
                                n_state = S_FIND;
                            end
                        end
                        OP_LOAD: begin
                            if (load_ok) begin
                                n_idx   = CW'(in_sel[2:0]);
                                n_state = S_LOAD;
                            end
                        end
                        OP_SAVE: begin
                            if (act_n == '0) begin
                                n_state = S_DONE;
                            end else if (pick_ok) begin
                                n_idx   = CW'(in_sel[2:0]);
                                n_state = S_PICK;
                            end else begin
                                n_idx   = '0;
                                n_prev  = SEQ_START;
                                n_seen  = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_FIND: begin
                if (cur_valid && (rd_data.addr == r_addr)) begin
                    n_res_slot = SLOT_W'(r_idx);
                    n_res_hit  = 1'b1;
                    n_state    = S_DONE;
                end else if (last) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = CW'(r_idx + 1'b1);
                end
            end
            S_LOAD: begin
                n_res_slot = SLOT_W'(r_idx);
                n_res_hit  = cur_valid;
                n_res_seq  = cur_valid ? rd_data.seq : '0;
                n_res_ld   = cur_valid;
                n_state    = S_DONE;
            end
            S_PICK: begin
                n_wseq  = cur_valid ? rd_data.seq : r_seqg;
                n_state = S_WRITE;
            end
            S_SCAN: begin
                if (!cur_valid || (r_seen && (rd_data.seq != seq_inc))) begin
                    n_wseq  = seq_inc;
                    n_state = S_WRITE;
                end else begin
                    n_prev = rd_data.seq;
                    n_seen = 1'b1;
                    if (last) begin
                        // no gap found: wrap to the first slot
                        n_idx   = '0;
                        n_wseq  = rd_data.seq + 1'b1;
                        n_state = S_WRITE;
                    end else begin
                        n_idx = CW'(r_idx + 1'b1);
                    end
                end
            end
            S_WRITE: begin
                wr_en      = 1'b1;
                n_res_slot = SLOT_W'(r_idx);
                n_res_hit  = 1'b1;
                n_res_seq  = r_wseq;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_seen  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_seen  <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev     <= n_prev;
        r_wseq     <= n_wseq;
        r_res_slot <= n_res_slot;
        r_res_hit  <= n_res_hit;
        r_res_seq  <= n_res_seq;
        r_res_ld   <= n_res_ld;
        if (accept) begin
            r_addr    <= s_tdata[53:6];
            r_seqg    <= s_tdata[61:54];
            r_cal_lo  <= s_tdata[125:62];
            r_cal_mid <= s_tdata[189:126];
            r_cal_hi  <= s_tdata[253:190];
        end
    end

    assign wr_data = '{seq: r_wseq, addr: r_addr, cal_lo: r_cal_lo,
                       cal_mid: r_cal_mid, cal_hi: r_cal_hi};

    kls_slot_mem #(
        .DEPTH (MAX_SLOTS),
        .IW    (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_idx  (n_idx[IW-1:0]),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_idx  (r_idx[IW-1:0]),
        .i_wr_data (wr_data),
        .o_valid   (valid_vec)
    );

    // result register
    assign out_load = (r_state == S_DONE) && (!r_ov || m_tready);
    assign o_addr   = r_res_ld ? rd_data.addr    : '0;
    assign o_lo     = r_res_ld ? rd_data.cal_lo  : '0;
    assign o_mid    = r_res_ld ? rd_data.cal_mid : '0;
    assign o_hi     = r_res_ld ? rd_data.cal_hi  : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_otd <= {3'b000, o_hi, o_mid, o_lo, o_addr, r_res_seq, r_res_hit, r_res_slot};
        end
    end

    assign m_tvalid = r_ov;
    assign m_tdata  = r_otd;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= SLOTS_RST;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SLOTS)) begin
            r_cfg <= pwdata[CFG_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SLOTS) ? {{(32-CFG_W){1'b0}}, r_cfg} : '0;

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> (r_idx < act_n))
        else $error("slot write outside the slots in use");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the done step");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_idx < CW'(MAX_SLOTS)))
        else $error("slot index beyond the store");

endmodule

@@ rtl/core/kls_slot_mem.sv @@
// kls_slot_mem: slot contents memory with registered read, plus per-slot valid flags
// depends on kls_pkg (t_slot)
module kls_slot_mem #(
    parameter int DEPTH = 8,
    parameter int IW    = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [IW-1:0]        i_rd_idx,
    output kls_pkg::t_slot       o_rd_data,
    input  logic                 i_wr_en,
    input  logic [IW-1:0]        i_wr_idx,
    input  kls_pkg::t_slot       i_wr_data,
    output logic [DEPTH-1:0]     o_valid
);
    import kls_pkg::*;

    t_slot            r_mem [DEPTH];
    t_slot            r_rd;
    logic [DEPTH-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        r_rd <= r_mem[i_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_idx] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd;
    assign o_valid   = r_valid;

endmodule

@@ tb/keyed_slot_log_store_tb.sv @@
// keyed_slot_log_store_tb: self-checking bench for the keyed slot log store
// drives requests and apb writes, predicts every result and compares it field by field
// depends on kls_pkg and keyed_slot_log_store
module keyed_slot_log_store_tb;
    import kls_pkg::*;

    localparam int TB_SLOTS  = 8;
    localparam int PHASES    = 10;
    localparam int PER_PHASE = 125;
    localparam int HOLD_LEN  = 300;

    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic signed [3:0] sel;
        logic [ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]  seq;
        logic [CAL_W-1:0]  cal_lo;
        logic [CAL_W-1:0]  cal_mid;
        logic [CAL_W-1:0]  cal_hi;
    } t_request;

    typedef struct packed {
        logic signed [3:0] slot_used;
        logic              entry_valid;
        logic [SEQ_W-1:0]  seq;
        logic [ADDR_W-1:0] addr;
        logic [CAL_W-1:0]  cal_lo;
        logic [CAL_W-1:0]  cal_mid;
        logic [CAL_W-1:0]  cal_hi;
    } t_result;

    class slot_store_tracker;
        logic [CFG_W-1:0]  slot_count;
        logic              valid[TB_SLOTS];
        logic [SEQ_W-1:0]  seq[TB_SLOTS];
        logic [ADDR_W-1:0] addr[TB_SLOTS];
        logic [CAL_W-1:0]  rec[TB_SLOTS][3];
        t_result           awaited[$];
        int errors, requests, finds, hits, loads, saves, wraps;

        function new();
            slot_count = SLOTS_RST;
            for (int i = 0; i < TB_SLOTS; i++) begin
                valid[i] = 1'b0;
                seq[i]   = '0;
                addr[i]  = '0;
                for (int w = 0; w < 3; w++) rec[i][w] = '0;
            end
            errors = 0;
            requests = 0;
            finds = 0;
            hits = 0;
            loads = 0;
            saves = 0;
            wraps = 0;
        endfunction

        function void note_request(t_request r);
            t_result          want;
            int               n;
            int               tgt;
            int               idx;
            logic [SEQ_W-1:0] prev;
            logic [SEQ_W-1:0] put_seq;
            logic             seen;
            logic             chosen;
            want = '0;
            want.slot_used = NO_SLOT;
            n = (slot_count < TB_SLOTS) ? int'(slot_count) : TB_SLOTS;
            idx = r.sel;
            requests++;
            case (r.op)
                OP_FIND: begin
                    finds++;
                    for (int i = 0; i < n && !want.entry_valid; i++) begin
                        if (valid[i] && addr[i] == r.addr) begin
                            want.slot_used   = 4'(i);
                            want.entry_valid = 1'b1;
                        end
                    end
                    if (want.entry_valid) hits++;
                end
                OP_LOAD: begin
                    loads++;
                    if (idx >= 0 && idx < TB_SLOTS) begin
                        want.slot_used = r.sel;
                        if (valid[idx]) begin
                            want.entry_valid = 1'b1;
                            want.seq     = seq[idx];
                            want.addr    = addr[idx];
                            want.cal_lo  = rec[idx][0];
                            want.cal_mid = rec[idx][1];
                            want.cal_hi  = rec[idx][2];
                        end
                    end
                end
                OP_SAVE: begin
                    saves++;
                    if (n != 0) begin
                        if (idx >= 0 && idx < n) begin
                            tgt = idx;
                            put_seq = valid[tgt] ? seq[tgt] : r.seq;
                        end else begin
                            // first empty slot or first break in the sequence, else wrap
                            prev = SEQ_START;
                            seen = 1'b0;
                            chosen = 1'b0;
                            tgt = 0;
                            for (int i = 0; i < n && !chosen; i++) begin
                                if (!valid[i] || (seen && seq[i] != SEQ_W'(prev + 1'b1))) begin
                                    tgt = i;
                                    chosen = 1'b1;
                                end else begin
                                    seen = 1'b1;
                                    prev = seq[i];
                                end
                            end
                            if (!chosen) wraps++;
                            put_seq = prev + 1'b1;
                        end
                        valid[tgt]  = 1'b1;
                        seq[tgt]    = put_seq;
                        addr[tgt]   = r.addr;
                        rec[tgt][0] = r.cal_lo;
                        rec[tgt][1] = r.cal_mid;
                        rec[tgt][2] = r.cal_hi;
                        want.slot_used   = 4'(tgt);
                        want.entry_valid = 1'b1;
                        want.seq         = put_seq;
                    end
                end
                default: ;
            endcase
            awaited.push_back(want);
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %h got %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [TD_W-1:0] data);
            t_result want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result %h", $time, data);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare("slot_used", want.slot_used, $signed(data[3:0]));
            compare("entry_valid", want.entry_valid, data[4]);
            compare("seq_out", want.seq, data[12:5]);
            compare("addr_out", want.addr, data[60:13]);
            compare("cal_out_lo", want.cal_lo, data[124:61]);
            compare("cal_out_mid", want.cal_mid, data[188:125]);
            compare("cal_out_hi", want.cal_hi, data[252:189]);
        endfunction
    endclass

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [TD_W-1:0]   s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [TD_W-1:0]   m_tdata;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [2:0]        paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    slot_store_tracker tracker;
    logic [ADDR_W-1:0] addr_pool[8];
    int                settings    = 0;
    int                burst_left  = 0;
    bit                steady      = 1'b0;
    int                holds_asked = 0;
    int                holds_done  = 0;
    int                hold_left   = 0;
    int                ready_mode  = 0;
    int                rx_cycle    = 0;

    keyed_slot_log_store #(.MAX_SLOTS(TB_SLOTS)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2;
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
    end

    // result side: check, then pick the next ready value
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready) tracker.check_result(m_tdata);
            rx_cycle++;
            if (rx_cycle % 128 == 0) ready_mode = $urandom_range(0, 2);
            if (holds_asked != holds_done) begin
                holds_done++;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (ready_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ($urandom_range(0, 2) == 0);
                endcase
            end
        end
    end

    function automatic t_request make_req(logic [1:0] op, int sel, logic [ADDR_W-1:0] addr,
                                          logic [SEQ_W-1:0] seq, logic [CAL_W-1:0] lo,
                                          logic [CAL_W-1:0] mid, logic [CAL_W-1:0] hi);
        t_request r;
        r.op      = op;
        r.sel     = 4'(sel);
        r.addr    = addr;
        r.seq     = seq;
        r.cal_lo  = lo;
        r.cal_mid = mid;
        r.cal_hi  = hi;
        return r;
    endfunction

    function automatic t_request random_req();
        int                pick;
        int                sel;
        logic [1:0]        op;
        logic [ADDR_W-1:0] a;
        pick = $urandom_range(0, 9);
        a = (pick < 7) ? addr_pool[$urandom_range(0, 7)] : {16'($urandom), 32'($urandom)};
        pick = $urandom_range(0, 99);
        op = (pick < 30) ? OP_FIND : ((pick < 55) ? OP_LOAD : OP_SAVE);
        sel = ($urandom_range(0, 9) < 3) ? -1 : int'($urandom_range(0, 7));
        return make_req(op, sel, a, 8'($urandom), {$urandom, $urandom},
                        {$urandom, $urandom}, {$urandom, $urandom});
    endfunction

    task automatic send(t_request r);
        int gap;
        if (burst_left == 0) begin
            gap = steady ? 0 : int'($urandom_range(0, 6));
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tdata  <= {2'b00, r.cal_hi, r.cal_mid, r.cal_lo, r.seq, r.addr, r.sel, r.op};
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        tracker.note_request(r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_slot_count(logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_SLOTS, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.slot_count = value;
        settings++;
    endtask

    initial begin
        #2000000;
        $display("keyed_slot_log_store test failed");
        $finish;
    end

    initial begin
        int cfg_plan[PHASES];
        cfg_plan = '{8, 1, 3, 6, 2, 8, 4, 13, 7, 8};
        tracker = new();
        foreach (addr_pool[k]) addr_pool[k] = {16'($urandom), 32'($urandom)};
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_slot_count(4'd8);

        // empty store, out of range load, spare op code
        send(make_req(OP_FIND, 0, '1, 8'd0, '0, '0, '0));
        send(make_req(OP_LOAD, 0, '0, 8'd0, '0, '0, '0));
        send(make_req(OP_LOAD, -1, '0, 8'd0, '0, '0, '0));
        send(make_req(OP_SPARE, 2, '1, 8'hFF, '1, '1, '1));
        // chosen saves, keep old sequence on a valid slot
        send(make_req(OP_SAVE, 7, '1, 8'hFF, '1, '1, '1));
        send(make_req(OP_LOAD, 7, '0, 8'd0, '0, '0, '0));
        send(make_req(OP_SAVE, 7, '1, 8'd0, 64'h0123_4567_89ab_cdef, '0, '1));
        // automatic saves: empty slots, then a break in the sequence
        send(make_req(OP_SAVE, -1, '0, 8'd77, '0, '0, '0));
        send(make_req(OP_SAVE, -1, addr_pool[2], 8'd0, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom}));
        send(make_req(OP_SAVE, 3, addr_pool[3], 8'd9, '1, '0, '1));
        send(make_req(OP_SAVE, -1, addr_pool[4], 8'd0, '0, '1, '0));
        send(make_req(OP_SAVE, -1, addr_pool[5], 8'd0, '1, '1, '0));
        send(make_req(OP_FIND, 0, '1, 8'd0, '0, '0, '0));
        send(make_req(OP_FIND, 0, '0, 8'd0, '0, '0, '0));
        send(make_req(OP_LOAD, 3, '0, 8'd0, '0, '0, '0));
        drain();
        // two slots in use: wrap, ignored upper slots, index past count
        write_slot_count(4'd2);
        send(make_req(OP_SAVE, -1, addr_pool[6], 8'd0, '0, '0, '1));
        send(make_req(OP_FIND, 0, '1, 8'd0, '0, '0, '0));
        send(make_req(OP_LOAD, 7, '0, 8'd0, '0, '0, '0));
        send(make_req(OP_SAVE, 5, addr_pool[7], 8'd3, '1, '1, '1));
        drain();
        // zero slots in use
        write_slot_count(4'd0);
        send(make_req(OP_FIND, 0, '0, 8'd0, '0, '0, '0));
        send(make_req(OP_SAVE, 0, '1, 8'd5, '1, '1, '1));
        send(make_req(OP_LOAD, 0, '0, 8'd0, '0, '0, '0));
        drain();
        write_slot_count(4'd15);
        send(make_req(OP_SAVE, -1, addr_pool[2], 8'd1, '0, '1, '1));
        send(make_req(OP_FIND, 0, addr_pool[2], 8'd0, '0, '0, '0));

        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_slot_count(4'(cfg_plan[p]));
            steady = (p == 5);
            if (p == 3) holds_asked++;
            repeat (PER_PHASE) send(random_req());
        end
        drain();
        repeat (20) @(posedge i_clk);

        $display("ran %0d requests: %0d finds (%0d hits), %0d loads, %0d saves (%0d wraps)",
                 tracker.requests, tracker.finds, tracker.hits, tracker.loads,
                 tracker.saves, tracker.wraps);
        $display("over %0d slot count settings, with sender gaps and result back-pressure",
                 settings);
        if (tracker.errors == 0) begin
            $display("keyed_slot_log_store test passed");
        end else begin
            $display("keyed_slot_log_store test failed");
        end
        $finish;
    end

endmodule
